// File: src/lkv_pkg.sv
// Shared constants for the LRU key/value cache.
// Field widths, operation codes and default sizing; no dependencies.
package lkv_pkg;

    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 31;
    localparam int CAP_W         = 5;
    localparam int ENTRIES_DFLT  = 16;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic KIND_GET = 1'b0;
    localparam logic KIND_SET = 1'b1;

endpackage

// File: src/lru_key_value_cache.sv
// Top level of the fully associative LRU key/value cache.
// Depends on lkv_pkg for field widths, the reset capacity and operation codes.
//
// Usage: an item (kind, key, value) is taken at a clock edge where start is high
// and busy is low. A get answers with one result, marked by o_result_valid for
// exactly one cycle; a set answers with nothing. Results cannot be held off.
// Each item is handled by a sequencer that walks the entry memory with one key
// comparator and one rank adder, one entry per cycle:
//   search pass over every entry, then a decide step;
//   update pass over every entry (get hit and every set).
// A get result is registered in the decide step. busy stays high until the end
// of the decide step on a get miss and of the update pass otherwise, so a new
// item cannot be taken before the last one is through.
// The capacity register is written through the cfg channel while the block is
// idle and start is low; a write empties the cache. Reset empties the cache and
// sets the capacity to 16. Entry contents live in memory and are never cleared;
// only the valid bits and the entry count are reset.
module lru_key_value_cache #(
    parameter int ENTRIES = lkv_pkg::ENTRIES_DFLT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_kind,
    input  logic signed [lkv_pkg::KEY_W-1:0]    i_key,
    input  logic        [lkv_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_result_valid,
    output logic                                o_found,
    output logic        [lkv_pkg::VALUE_W-1:0]  o_read_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic        [lkv_pkg::CAP_W-1:0]    i_cfg_capacity
);

    import lkv_pkg::*;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [VALUE_W-1:0] value;
        logic [RANK_W-1:0]  rank;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DECIDE,
        ST_UPDATE
    } t_state;

    t_state             r_state;
    t_entry             r_mem [ENTRIES];
    t_entry             r_rd_data;
    logic [ENTRIES-1:0] r_valid;
    logic [CNT_W-1:0]   r_count;
    logic [CAP_W-1:0]   r_capacity;

    logic               r_kind;
    logic [KEY_W-1:0]   r_key;
    logic [VALUE_W-1:0] r_value;

    logic [IDX_W-1:0]   r_addr;
    logic               r_issue;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pend_idx;

    logic               r_hit;
    logic [IDX_W-1:0]   r_slot;
    logic [RANK_W-1:0]  r_hit_rank;
    logic [VALUE_W-1:0] r_hit_value;
    logic               r_free_ok;
    logic [IDX_W-1:0]   r_free;
    logic [IDX_W-1:0]   r_old;
    logic               r_insert;
    logic [IDX_W-1:0]   r_target;

    logic               r_res_valid;
    logic               r_found;
    logic [VALUE_W-1:0] r_read_value;

    logic               pend_valid;
    logic               key_match;
    logic               is_oldest;
    logic               is_full;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   cap_ext;
    logic               mem_we;
    t_entry             mem_wdata;

    always_comb begin
        pend_valid = r_valid[r_pend_idx];
        key_match  = pend_valid && (r_rd_data.key == r_key);
        is_oldest  = pend_valid && (CNT_W'(r_rd_data.rank) == (r_count - 1'b1));
        cnt_ext    = CMP_W'(r_count);
        cap_ext    = (r_capacity == '0) ? CMP_W'(1) : CMP_W'(r_capacity);
        is_full    = (cnt_ext >= cap_ext) || (cnt_ext >= CMP_W'(ENTRIES));
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = r_rd_data;
        if (r_state == ST_UPDATE && r_pend) begin
            if (r_pend_idx == r_target) begin
                mem_we          = 1'b1;
                mem_wdata.key   = r_key;
                mem_wdata.value = (r_kind == KIND_SET) ? r_value : r_rd_data.value;
                mem_wdata.rank  = '0;
            end else if (pend_valid && (r_insert || (r_rd_data.rank < r_hit_rank))) begin
                mem_we         = 1'b1;
                mem_wdata.rank = r_rd_data.rank + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[r_pend_idx] <= mem_wdata;
        end
        r_rd_data <= r_mem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_issue     <= 1'b0;
            r_pend      <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= 1'b0;
            if (r_issue) begin
                r_pend     <= 1'b1;
                r_pend_idx <= r_addr;
                if (r_addr == LAST_IDX) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end else begin
                r_pend <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_kind    <= i_kind;
                        r_key     <= $unsigned(i_key);
                        r_value   <= i_value;
                        r_addr    <= '0;
                        r_issue   <= 1'b1;
                        r_pend    <= 1'b0;
                        r_hit     <= 1'b0;
                        r_free_ok <= 1'b0;
                        r_old     <= '0;
                        r_state   <= ST_SEARCH;
                    end else if (i_cfg_valid) begin
                        r_capacity <= i_cfg_capacity;
                        r_valid    <= '0;
                        r_count    <= '0;
                    end
                end
                ST_SEARCH: begin
                    if (r_pend) begin
                        if (key_match && !r_hit) begin
                            r_hit       <= 1'b1;
                            r_slot      <= r_pend_idx;
                            r_hit_rank  <= r_rd_data.rank;
                            r_hit_value <= r_rd_data.value;
                        end
                        if (!pend_valid && !r_free_ok) begin
                            r_free_ok <= 1'b1;
                            r_free    <= r_pend_idx;
                        end
                        if (is_oldest) begin
                            r_old <= r_pend_idx;
                        end
                        if (r_pend_idx == LAST_IDX) begin
                            r_state <= ST_DECIDE;
                        end
                    end
                end
                ST_DECIDE: begin
                    r_addr  <= '0;
                    r_pend  <= 1'b0;
                    if (r_kind == KIND_GET) begin
                        r_res_valid  <= 1'b1;
                        r_found      <= r_hit;
                        r_read_value <= r_hit ? r_hit_value : '0;
                    end
                    if (r_hit) begin
                        r_insert <= 1'b0;
                        r_target <= r_slot;
                        r_issue  <= 1'b1;
                        r_state  <= ST_UPDATE;
                    end else if (r_kind == KIND_SET) begin
                        r_insert <= 1'b1;
                        r_issue  <= 1'b1;
                        r_state  <= ST_UPDATE;
                        if (is_full) begin
                            r_valid[r_old] <= 1'b0;
                            if (r_free_ok && (r_free < r_old)) begin
                                r_target         <= r_free;
                                r_valid[r_free]  <= 1'b1;
                            end else begin
                                r_target         <= r_old;
                                r_valid[r_old]   <= 1'b1;
                            end
                        end else begin
                            r_target        <= r_free;
                            r_valid[r_free] <= 1'b1;
                            r_count         <= r_count + 1'b1;
                        end
                    end else begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_UPDATE: begin
                    if (r_pend && (r_pend_idx == LAST_IDX)) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = (r_state == ST_IDLE) && !start;
    assign o_result_valid = r_res_valid;
    assign o_found        = r_found;
    assign o_read_value   = r_read_value;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CMP_W'(r_count) <= CMP_W'(ENTRIES))
        else $error("entry count above the number of entries");

    a_count_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> ($countones(r_valid) == int'(r_count)))
        else $error("entry count disagrees with the valid bits");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_found) |-> (o_read_value == '0))
        else $error("a miss carries a nonzero value");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("an item was taken without going busy");

    a_result_from_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == ST_DECIDE && r_kind == KIND_GET))
        else $error("a result appeared outside the decide step of a get");
`endif

endmodule

// File: bench/lru_key_value_cache_test.sv
`timescale 1ns / 1ps
// Self-checking bench for lru_key_value_cache: directed and random get/set traffic and capacity
// changes against a shadow LRU cache. Depends on lkv_pkg and the lru_key_value_cache RTL only.
module lru_key_value_cache_test;
    import lkv_pkg::*;

    localparam int SLOTS = ENTRIES_DFLT;
    localparam int SETTLE_CYCLES = 2 * SLOTS + 8;

    typedef enum logic [1:0] {OP_ITEM, OP_CAPACITY, OP_DRAIN} op_kind_e;
    typedef enum logic [2:0] {DRV_IDLE, DRV_GAP, DRV_ITEM, DRV_SETTLE, DRV_CFG} drv_state_e;

    typedef struct {
        op_kind_e              op;
        logic                  kind;
        logic [KEY_W-1:0]      key;
        logic [VALUE_W-1:0]    value;
        logic [CAP_W-1:0]      capacity;
        int unsigned           gap;
    } cache_op_t;

    typedef struct packed {
        logic                  found;
        logic [VALUE_W-1:0]    read_value;
    } lookup_answer_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   i_kind = KIND_GET;
    logic [KEY_W-1:0]       i_key = '0;
    logic [VALUE_W-1:0]     i_value = '0;
    logic                   o_result_valid;
    logic                   o_found;
    logic [VALUE_W-1:0]     o_read_value;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CAP_W-1:0]       i_cfg_capacity = '0;

    cache_op_t              cache_ops[$];
    lookup_answer_t         pending_lookups[$];
    int unsigned            errors = 0;
    bit                     burst_mode = 1'b0;

    logic [KEY_W-1:0]       slot_key[SLOTS];
    logic [VALUE_W-1:0]     slot_value[SLOTS];
    bit                     slot_valid[SLOTS];
    int unsigned            slot_rank[SLOTS];
    int unsigned            slot_count;
    int unsigned            cap_limit;

    drv_state_e             drv_state = DRV_IDLE;
    drv_state_e             nxt_state;
    cache_op_t              cur_op;
    int unsigned            gap_left;
    int unsigned            settle_left;
    logic                   nxt_start;
    logic                   nxt_cfg_valid;
    lookup_answer_t         want;

    lru_key_value_cache DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_kind         (i_kind),
        .i_key          (i_key),
        .i_value        (i_value),
        .o_result_valid (o_result_valid),
        .o_found        (o_found),
        .o_read_value   (o_read_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_capacity (i_cfg_capacity)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic void clear_cache(input logic [CAP_W-1:0] cap);
        for (int i = 0; i < SLOTS; i++) begin
            slot_valid[i] = 1'b0;
            slot_rank[i] = 0;
        end
        slot_count = 0;
        cap_limit = (cap < 1) ? 1 : ((cap > SLOTS) ? SLOTS : cap);
    endfunction

    function automatic void promote_entry(input int s);
        int unsigned r;
        r = slot_rank[s];
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
        end
        slot_rank[s] = 0;
    endfunction

    function automatic void apply_to_shadow_cache(input cache_op_t op);
        int hit;
        int free_slot;
        bit dropped;
        lookup_answer_t answer;
        hit = -1;
        free_slot = -1;
        dropped = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            if (hit < 0 && slot_valid[i] && slot_key[i] == op.key) hit = i;
        end
        if (op.kind == KIND_GET) begin
            answer.found = (hit >= 0);
            answer.read_value = (hit >= 0) ? slot_value[hit] : '0;
            if (hit >= 0) promote_entry(hit);
            pending_lookups.push_back(answer);
        end else if (hit >= 0) begin
            slot_value[hit] = op.value;
            promote_entry(hit);
        end else begin
            if (slot_count >= cap_limit && slot_count != 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!dropped && slot_valid[i] && slot_rank[i] == slot_count - 1) begin
                        slot_valid[i] = 1'b0;
                        slot_rank[i] = 0;
                        slot_count--;
                        dropped = 1'b1;
                    end
                end
            end
            for (int i = 0; i < SLOTS; i++) begin
                if (free_slot < 0 && !slot_valid[i]) free_slot = i;
            end
            if (free_slot >= 0) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_valid[i]) slot_rank[i]++;
                end
                slot_key[free_slot] = op.key;
                slot_value[free_slot] = op.value;
                slot_valid[free_slot] = 1'b1;
                slot_rank[free_slot] = 0;
                slot_count++;
            end
        end
    endfunction

    function automatic int unsigned draw_gap();
        if ($urandom_range(0, 19) == 0) burst_mode = !burst_mode;
        return burst_mode ? 0 : $urandom_range(0, 10);
    endfunction

    function automatic void add_item(input logic kind, input logic [KEY_W-1:0] key,
                                     input logic [VALUE_W-1:0] value);
        cache_op_t op;
        op.op = OP_ITEM;
        op.kind = kind;
        op.key = key;
        op.value = value;
        op.capacity = '0;
        op.gap = draw_gap();
        cache_ops.push_back(op);
    endfunction

    function automatic void add_control(input op_kind_e kind, input logic [CAP_W-1:0] cap);
        cache_op_t op;
        op.op = kind;
        op.kind = KIND_GET;
        op.key = '0;
        op.value = '0;
        op.capacity = cap;
        op.gap = draw_gap();
        cache_ops.push_back(op);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            drv_state <= DRV_IDLE;
            clear_cache(CAP_RESET);
        end else begin
            nxt_state = drv_state;
            nxt_start = start;
            nxt_cfg_valid = i_cfg_valid;
            if (start && !busy) begin
                apply_to_shadow_cache(cur_op);
                nxt_start = 1'b0;
                nxt_state = DRV_IDLE;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                clear_cache(cur_op.capacity);
                nxt_cfg_valid = 1'b0;
                nxt_state = DRV_IDLE;
            end
            if (nxt_state == DRV_IDLE && cache_ops.size() != 0) begin
                cur_op = cache_ops.pop_front();
                gap_left = cur_op.gap;
                nxt_state = DRV_GAP;
            end
            if (nxt_state == DRV_GAP) begin
                if (gap_left != 0) begin
                    gap_left--;
                end else if (cur_op.op == OP_ITEM) begin
                    nxt_start = 1'b1;
                    i_kind <= cur_op.kind;
                    i_key <= cur_op.key;
                    i_value <= cur_op.value;
                    nxt_state = DRV_ITEM;
                end else begin
                    settle_left = (cur_op.op == OP_CAPACITY) ? SETTLE_CYCLES : 0;
                    nxt_state = DRV_SETTLE;
                end
            end
            if (nxt_state == DRV_SETTLE) begin
                if (pending_lookups.size() != 0) begin
                    settle_left = (cur_op.op == OP_CAPACITY) ? SETTLE_CYCLES : 0;
                end else if (settle_left != 0) begin
                    settle_left--;
                end else if (cur_op.op == OP_DRAIN) begin
                    nxt_state = DRV_IDLE;
                end else if (!busy) begin
                    nxt_cfg_valid = 1'b1;
                    i_cfg_capacity <= cur_op.capacity;
                    nxt_state = DRV_CFG;
                end
            end
            start <= nxt_start;
            i_cfg_valid <= nxt_cfg_valid;
            drv_state <= nxt_state;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            if (pending_lookups.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got found=%0b value=%0h",
                         $time, o_found, o_read_value);
            end else begin
                want = pending_lookups.pop_front();
                if (o_found !== want.found) begin
                    errors++;
                    $display("%0t: found mismatch, expected %0b, got %0b",
                             $time, want.found, o_found);
                end
                if (o_read_value !== want.read_value) begin
                    errors++;
                    $display("%0t: read_value mismatch, expected %0h, got %0h",
                             $time, want.read_value, o_read_value);
                end
            end
        end
    end

    initial begin
        logic [CAP_W-1:0] phase_caps[11];
        logic [KEY_W-1:0] key_pool[$];
        logic [KEY_W-1:0] key;
        int unsigned eff;
        int unsigned pool_n;

        add_item(KIND_GET, '0, 31'h7FFFFFFF);
        add_item(KIND_SET, 32'h80000000, '0);
        add_item(KIND_SET, 32'h7FFFFFFF, 31'h7FFFFFFF);
        add_item(KIND_SET, 32'h00000000, 31'd1);
        add_item(KIND_SET, 32'hFFFFFFFF, 31'h2AAAAAAA);
        add_item(KIND_GET, 32'h80000000, '0);
        add_item(KIND_GET, 32'h7FFFFFFF, '0);
        add_item(KIND_SET, 32'h00000000, 31'd5);
        add_item(KIND_GET, 32'h00000000, 31'h55555555);
        add_item(KIND_GET, 32'h12345678, 31'h1);
        add_control(OP_CAPACITY, 5'd1);
        add_item(KIND_GET, 32'h80000000, '0);
        add_item(KIND_SET, 32'd1, 31'd10);
        add_item(KIND_SET, 32'd2, 31'd20);
        add_item(KIND_GET, 32'd1, '0);
        add_item(KIND_GET, 32'd2, '0);
        add_control(OP_CAPACITY, 5'd0);
        add_item(KIND_SET, 32'd3, 31'd30);
        add_item(KIND_SET, 32'd4, 31'd40);
        add_item(KIND_GET, 32'd3, '0);
        add_item(KIND_GET, 32'd4, '0);
        add_control(OP_CAPACITY, 5'd2);
        add_item(KIND_SET, 32'd5, 31'd50);
        add_item(KIND_SET, 32'd6, 31'd60);
        add_item(KIND_GET, 32'd5, '0);
        add_item(KIND_SET, 32'd7, 31'd70);
        add_item(KIND_GET, 32'd6, '0);
        add_item(KIND_GET, 32'd5, '0);
        add_item(KIND_GET, 32'd7, '0);

        phase_caps = '{5'd31, 5'd1, 5'd16, 5'd3, 5'd0, 5'd8, 5'd17,
                       5'($urandom), 5'd2, 5'd12, 5'($urandom)};
        foreach (phase_caps[p]) begin
            add_control(OP_CAPACITY, phase_caps[p]);
            eff = (phase_caps[p] < 1) ? 1 : ((phase_caps[p] > SLOTS) ? SLOTS : phase_caps[p]);
            pool_n = eff + $urandom_range(1, eff / 2 + 3);
            key_pool.delete();
            for (int k = 0; k < pool_n; k++) begin
                case ($urandom_range(0, 7))
                    0: key_pool.push_back(32'h80000000 | 32'($urandom_range(0, 3)));
                    1: key_pool.push_back(32'h7FFFFFFF - 32'($urandom_range(0, 3)));
                    default: key_pool.push_back($urandom);
                endcase
            end
            for (int n = 0; n < 150; n++) begin
                if (n == 75) add_control(OP_DRAIN, '0);
                key = ($urandom_range(0, 9) == 0) ? $urandom
                                                   : key_pool[$urandom_range(0, pool_n - 1)];
                add_item($urandom_range(0, 1) ? KIND_SET : KIND_GET, key, 31'($urandom));
            end
        end

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cache_ops.size() != 0 || drv_state != DRV_IDLE || pending_lookups.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0 && pending_lookups.size() == 0) begin
            $display("lru_key_value_cache_test OK");
        end else begin
            $display("lru_key_value_cache_test NOT OK");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("lru_key_value_cache_test NOT OK");
        $finish;
    end

endmodule
